FILE: rtl/core/log_delta_rle_decoder_unit_macros.svh
// Assertion macros used by the decoder RTL.
`ifndef LOG_DELTA_RLE_DECODER_UNIT_MACROS_SVH
`define LOG_DELTA_RLE_DECODER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define LDR_ASSERT_ALWAYS(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
    else $error("assertion failed");

`define LDR_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

`define LDR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define LDR_ASSERT_ALWAYS(lbl, clk, rstn, cond)
`define LDR_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define LDR_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

FILE: rtl/core/ldrle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldrle_pkg
// Types and constants of the log-delta run-length audio decoder.
// ----------------------------------------------------------------------------
package ldrle_pkg;

  localparam int unsigned RESULT_DEPTH = 4;
  localparam int unsigned CFG_ADDR_W   = 3;
  localparam int unsigned REM_W        = 18;

  // Register index within the configuration space.
  localparam logic [0:0] REG_BLOCK_WORDS = 1'b0;

  // Prefix codes of the compressed stream.
  localparam logic [7:0] CODE_LITERAL = 8'h00;
  localparam logic [7:0] CODE_RUN8    = 8'h01;
  localparam logic [7:0] CODE_RUN16   = 8'h02;

  typedef enum logic [2:0] {
    MODE_NORMAL   = 3'd0,
    MODE_LITERAL  = 3'd1,
    MODE_RUN8     = 3'd2,
    MODE_RUN16_LO = 3'd3,
    MODE_RUN16_HI = 3'd4
  } mode_e;

  typedef struct packed {
    logic [7:0]  sample;
    logic [15:0] repeat_cnt;
    logic        last;
    logic        done;
  } result_t;

  // Signed log-delta steps, two's complement.
  localparam logic [7:0] STEP_TABLE [16] = '{
    8'h00, 8'hFE, 8'hFC, 8'hF8, 8'hF0, 8'hE0, 8'hC0, 8'h81,
    8'h00, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h7F
  };

endpackage

FILE: rtl/core/log_delta_rle_decoder_unit.sv
`timescale 1ns / 1ps
// Results are registered into the result queue as their code bytes transfer.
// Throughput: one code byte per cycle while code_stall_o is low. A nibble-pair
// byte yields two results and the single result port drains one per cycle, so
// pair bytes fill the small result queue, which also absorbs output stalls.
// Reset: block_words is 1, the running sample is 0, the queue is empty.
// ----------------------------------------------------------------------------
// log_delta_rle_decoder_unit
// Decodes a log-delta run-length compressed 8-bit audio stream, one byte per
// transfer, into sample results that each carry a repeat count.
// ----------------------------------------------------------------------------
`include "log_delta_rle_decoder_unit_macros.svh"

module log_delta_rle_decoder_unit
  import ldrle_pkg::*;
#(
  parameter int unsigned ResultDepth = RESULT_DEPTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  // Code byte input
  input  logic                  code_valid_i,
  output logic                  code_stall_o,
  input  logic [7:0]            code_byte_i,
  // Result output
  output logic                  res_valid_o,
  input  logic                  res_stall_i,
  output logic signed [7:0]     sample_o,
  output logic [15:0]           repeat_res_o,
  output logic                  last_of_run_o,
  output logic                  block_done_o
);

  localparam int unsigned PtrW = (ResultDepth > 1) ? $clog2(ResultDepth) : 1;
  localparam int unsigned CntW = $clog2(ResultDepth + 1);

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    return (p == PtrW'(ResultDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [REM_W-1:0] reload_of(input logic [15:0] w);
    logic [15:0] wz;
    wz = (w == '0) ? 16'd1 : w;
    return {1'b0, wz, 1'b0};
  endfunction

  // Control and block state
  mode_e            mode_q, mode_d;
  logic [7:0]       rs_q, rs_d;
  logic [7:0]       low_q, low_d;
  logic [REM_W-1:0] rem_q, rem_d;
  logic [15:0]      bw_q, bw_d;

  // Result queue
  result_t          fifo_q [ResultDepth];
  logic [PtrW-1:0]  wptr_q, wptr_d, wptr1;
  logic [PtrW-1:0]  rptr_q, rptr_d;
  logic [CntW-1:0]  count_q, count_d;

  logic             accept, pop, cfg_wr, cfg_sel;
  logic [1:0]       push_n;
  result_t          ent0, ent1;
  logic [15:0]      used;
  logic             has_res;
  logic [REM_W-1:0] rem_next;
  logic             done;
  logic [7:0]       s1, s2;

  assign pready  = 1'b1;
  assign cfg_sel = (paddr[CFG_ADDR_W-1:2] == REG_BLOCK_WORDS);
  assign cfg_wr  = psel && penable && pwrite && pready && cfg_sel;
  assign prdata  = cfg_sel ? {16'h0000, bw_q} : 32'h0;

  // Stall only on the queue fill so that stall never loops back from the output.
  assign code_stall_o = (count_q > CntW'(ResultDepth - 2));
  assign accept       = code_valid_i && !code_stall_o;
  assign res_valid_o  = (count_q != '0);
  assign pop          = res_valid_o && !res_stall_i;

  assign s1       = rs_q + STEP_TABLE[code_byte_i[7:4]];
  assign s2       = s1 + STEP_TABLE[code_byte_i[3:0]];
  assign rem_next = rem_q - {2'b00, used};
  assign done     = rem_next[REM_W-1] || (rem_next == '0);

  always_comb begin
    mode_d  = mode_q;
    rs_d    = rs_q;
    low_d   = low_q;
    rem_d   = rem_q;
    bw_d    = bw_q;
    push_n  = 2'd0;
    has_res = 1'b0;
    used    = 16'd0;
    ent0    = '{sample: rs_q, repeat_cnt: 16'd1, last: 1'b0, done: 1'b0};
    ent1    = '{sample: s2, repeat_cnt: 16'd1, last: 1'b0, done: 1'b0};

    if (accept) begin
      unique case (mode_q)
        MODE_LITERAL: begin
          rs_d            = code_byte_i;
          ent0.sample     = code_byte_i;
          ent0.repeat_cnt = 16'd2;
          used            = 16'd2;
          push_n          = 2'd1;
          has_res         = 1'b1;
          mode_d          = MODE_NORMAL;
        end
        MODE_RUN8: begin
          ent0.repeat_cnt = {8'h00, code_byte_i} + 16'd1;
          used            = ent0.repeat_cnt;
          push_n          = 2'd1;
          has_res         = 1'b1;
          mode_d          = MODE_NORMAL;
        end
        MODE_RUN16_LO: begin
          low_d  = code_byte_i;
          mode_d = MODE_RUN16_HI;
        end
        MODE_RUN16_HI: begin
          mode_d          = MODE_NORMAL;
          ent0.repeat_cnt = {code_byte_i, low_q};
          used            = ent0.repeat_cnt;
          // A zero count produces nothing and leaves the block count alone.
          if (ent0.repeat_cnt != '0) begin
            push_n  = 2'd1;
            has_res = 1'b1;
          end
        end
        default: begin
          mode_d = MODE_NORMAL;
          if (code_byte_i == CODE_LITERAL) begin
            mode_d = MODE_LITERAL;
          end else if (code_byte_i == CODE_RUN8) begin
            mode_d = MODE_RUN8;
          end else if (code_byte_i == CODE_RUN16) begin
            mode_d = MODE_RUN16_LO;
          end else begin
            ent0.sample = s1;
            rs_d        = s2;
            used        = 16'd2;
            push_n      = 2'd2;
            has_res     = 1'b1;
          end
        end
      endcase

      if (has_res) begin
        rem_d = rem_next;
        if (push_n == 2'd2) begin
          ent1.last = 1'b1;
          ent1.done = done;
        end else begin
          ent0.last = 1'b1;
          ent0.done = done;
        end
        // Block end: restart the parser, overshoot is dropped.
        if (done) begin
          mode_d = MODE_NORMAL;
          rs_d   = '0;
          low_d  = '0;
          rem_d  = reload_of(bw_q);
        end
      end
    end

    if (cfg_wr) begin
      bw_d   = pwdata[15:0];
      mode_d = MODE_NORMAL;
      rs_d   = '0;
      low_d  = '0;
      rem_d  = reload_of(pwdata[15:0]);
    end
  end

  assign wptr1   = ptr_next(wptr_q);
  assign wptr_d  = (push_n == 2'd2) ? ptr_next(wptr1) :
                   (push_n == 2'd1) ? wptr1 : wptr_q;
  assign rptr_d  = pop ? ptr_next(rptr_q) : rptr_q;
  assign count_d = count_q + CntW'(push_n) - CntW'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_NORMAL;
      rs_q    <= '0;
      low_q   <= '0;
      bw_q    <= 16'd1;
      rem_q   <= reload_of(16'd1);
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      mode_q  <= mode_d;
      rs_q    <= rs_d;
      low_q   <= low_d;
      bw_q    <= bw_d;
      rem_q   <= rem_d;
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < ResultDepth; i++) begin
      if (push_n != 2'd0 && PtrW'(i) == wptr_q) begin
        fifo_q[i] <= ent0;
      end else if (push_n == 2'd2 && PtrW'(i) == wptr1) begin
        fifo_q[i] <= ent1;
      end
    end
  end

  assign sample_o      = $signed(fifo_q[rptr_q].sample);
  assign repeat_res_o  = fifo_q[rptr_q].repeat_cnt;
  assign last_of_run_o = fifo_q[rptr_q].last;
  assign block_done_o  = fifo_q[rptr_q].done;

  `LDR_ASSERT_ALWAYS(a_count_bound, clk_i, rst_ni, count_q <= CntW'(ResultDepth))
  `LDR_ASSERT_IMPL(a_done_is_last, clk_i, rst_ni, res_valid_o && block_done_o, last_of_run_o)
  `LDR_ASSERT_IMPL(a_repeat_nonzero, clk_i, rst_ni, res_valid_o, repeat_res_o != '0)
  `LDR_ASSERT_NEXT(a_block_restart, clk_i, rst_ni, has_res && done, mode_q == MODE_NORMAL)
  `LDR_ASSERT_NEXT(a_block_clear, clk_i, rst_ni, has_res && done, rs_q == '0 && low_q == '0)

endmodule
